### design/hfd_pkg.sv
// ----------------------------------------------------------------------------
// hfd_pkg
// shared types, item codes and fixed-point constants of the humidity fan
// decider
// ----------------------------------------------------------------------------
package hfd_pkg;

  // item kinds as they arrive on the input channel
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // operation codes carried from front to back
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_RUN    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // fixed-point widths
  localparam int unsigned AVG_W    = 23;   // Q7.16 filtered humidity
  localparam int unsigned HUM_W    = 7;    // integer percent
  localparam int unsigned SAMPLE_W = 23;   // sample*256 + rounding term
  localparam int unsigned TERM_W   = 50;   // sample term times tenth reciprocal
  localparam int unsigned MIX_W    = 53;   // avg times nine-tenths reciprocal
  localparam int unsigned SUM_W    = 54;
  localparam int unsigned RUN_MS_W = 26;

  // x/10 == (x * RECIP_TENTH) >> RECIP_SHIFT for every x below 2^27
  localparam int unsigned RECIP_SHIFT      = 30;
  localparam logic [26:0] RECIP_TENTH      = 27'd107374183;
  localparam logic [29:0] RECIP_NINE_TENTH = 30'd966367647;
  localparam logic [22:0] ROUND_HALF       = 23'd5;

  localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
  localparam logic [6:0]  TRIGGER_RESET = 7'd70;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [14:0] sensor_humidity;
    logic [15:0] run_seconds;
    logic [5:0]  log_index;
  } item_t;

  typedef struct packed {
    logic [6:0]  humidity_percent;
    logic        fan_on;
    logic        too_wet;
    logic        run_requested;
    logic [5:0]  log_count;
    logic        log_valid;
    logic [31:0] log_time;
    logic [6:0]  log_humidity;
  } result_t;

  // classified item as queued between front and back
  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       now_ms;
    logic [TERM_W-1:0] filter_term;
    logic [31:0]       run_end;
    logic              run_active;
    logic [5:0]        log_index;
  } op_t;

endpackage

### design/hfd_ram.sv
// ----------------------------------------------------------------------------
// hfd_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module hfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/hfd_front.sv
// ----------------------------------------------------------------------------
// hfd_front
// accepts requests, classifies them, precomputes state-free arithmetic and
// queues them for the back end
// ----------------------------------------------------------------------------
module hfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  hfd_pkg::item_t item,
  output logic          q_valid,
  output hfd_pkg::op_t  q_op,
  input  logic          q_pop
);

  logic [1:0]                      op;
  logic [hfd_pkg::SAMPLE_W-1:0]    sample_term;
  logic [hfd_pkg::TERM_W-1:0]      filter_term;
  logic [hfd_pkg::RUN_MS_W-1:0]    run_ms;
  logic [31:0]                     run_end;
  hfd_pkg::op_t                    op_in;
  hfd_pkg::op_t                    entries [2];
  logic                            wptr;
  logic                            rptr;
  logic [1:0]                      count;
  logic                            push;

  always_comb begin
    unique case (item.kind)
      hfd_pkg::KIND_UPDATE: op = hfd_pkg::OP_UPDATE;
      hfd_pkg::KIND_RUN:    op = hfd_pkg::OP_RUN;
      hfd_pkg::KIND_READ:   op = hfd_pkg::OP_READ;
      default:              op = hfd_pkg::OP_STATUS;
    endcase
  end

  // sample*256 + 5 is at most 23 bits
  assign sample_term = {item.sensor_humidity, 8'b0} + hfd_pkg::ROUND_HALF;
  assign filter_term = hfd_pkg::TERM_W'(sample_term) *
                       hfd_pkg::TERM_W'(hfd_pkg::RECIP_TENTH);
  assign run_ms      = hfd_pkg::RUN_MS_W'(item.run_seconds) *
                       hfd_pkg::RUN_MS_W'(hfd_pkg::MS_PER_SECOND);
  assign run_end     = item.now_ms + 32'(run_ms);

  always_comb begin
    op_in.op          = op;
    op_in.now_ms      = item.now_ms;
    op_in.filter_term = filter_term;
    op_in.run_end     = run_end;
    op_in.run_active  = item.now_ms < run_end;
    op_in.log_index   = item.log_index;
  end

  // two-entry queue
  assign item_ready = count != 2'd2;
  assign push       = item_valid && item_ready;
  assign q_valid    = count != 2'd0;
  assign q_op       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### design/hfd_back.sv
// ----------------------------------------------------------------------------
// hfd_back
// executes queued requests: filter step, timed run, change log append and
// log read, and holds the result register
// ----------------------------------------------------------------------------
module hfd_back #(
  parameter int unsigned LOG_DEPTH        = 60,
  parameter int unsigned FILTER_PERIOD_MS = 1000
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata,
  input  logic             q_valid,
  input  hfd_pkg::op_t     q_op,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_ready,
  output hfd_pkg::result_t result
);

  localparam int unsigned PW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned SW = PW + 7;
  localparam int unsigned EW = 39;
  localparam logic [PW-1:0] LAST_SLOT  = PW'(LOG_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(LOG_DEPTH);
  localparam logic [SW-1:0] DEPTH_S    = SW'(LOG_DEPTH);
  localparam logic [31:0]   PERIOD     = 32'(FILTER_PERIOD_MS);

  // state
  logic [hfd_pkg::AVG_W-1:0] avg;
  logic [31:0]               last_time;
  logic [31:0]               run_end;
  logic [PW-1:0]             oldest;
  logic [PW-1:0]             tail;
  logic [CW-1:0]             entries;
  logic [6:0]                last_value;
  logic [6:0]                trigger;

  // result register
  logic [6:0] res_hum;
  logic       res_req;
  logic [5:0] res_count;
  logic       res_read;

  logic                       is_update;
  logic                       is_run;
  logic                       is_read;
  logic [31:0]                elapsed;
  logic                       filter_due;
  logic [hfd_pkg::MIX_W-1:0]  mix;
  logic [hfd_pkg::SUM_W-1:0]  acc;
  logic [hfd_pkg::AVG_W-1:0]  avg_step;
  logic [hfd_pkg::AVG_W-1:0]  avg_next;
  logic [6:0]                 hum_next;
  logic                       append;
  logic                       full;
  logic [PW-1:0]              tail_inc;
  logic [PW-1:0]              oldest_inc;
  logic [CW-1:0]              entries_next;
  logic [CW+5:0]              idx_w;
  logic [CW+5:0]              cnt_w;
  logic [CW+5:0]              cnt_next_w;
  logic                       read_ok;
  logic [SW-1:0]              slot_sum;
  logic [SW-1:0]              slot_fix;
  logic [PW-1:0]              read_slot;
  logic                       req_next;
  logic                       ram_we;
  logic                       ram_re;
  logic [EW-1:0]              ram_wdata;
  logic [EW-1:0]              ram_rdata;

  assign q_pop = q_valid && (!result_valid || result_ready);

  assign is_update = q_op.op == hfd_pkg::OP_UPDATE;
  assign is_run    = q_op.op == hfd_pkg::OP_RUN;
  assign is_read   = q_op.op == hfd_pkg::OP_READ;

  // filter step: (s*256 + 9*avg + 5) / 10 by reciprocal multiply
  assign elapsed    = q_op.now_ms - last_time;
  assign filter_due = is_update && (elapsed > PERIOD);
  assign mix        = hfd_pkg::MIX_W'(avg) * hfd_pkg::MIX_W'(hfd_pkg::RECIP_NINE_TENTH);
  assign acc        = hfd_pkg::SUM_W'(mix) + hfd_pkg::SUM_W'(q_op.filter_term);
  assign avg_step   = acc[hfd_pkg::RECIP_SHIFT +: hfd_pkg::AVG_W];
  assign avg_next   = filter_due ? avg_step : avg;
  assign hum_next   = avg_next[hfd_pkg::AVG_W-1 -: 7];

  // change log ring
  assign full         = entries == FULL_COUNT;
  assign append       = is_update && ((entries == '0) || (last_value != hum_next));
  assign tail_inc     = (tail == LAST_SLOT) ? '0 : tail + PW'(1);
  assign oldest_inc   = (oldest == LAST_SLOT) ? '0 : oldest + PW'(1);
  assign entries_next = (append && !full) ? entries + CW'(1) : entries;

  assign idx_w      = {{CW{1'b0}}, q_op.log_index};
  assign cnt_w      = {6'b0, entries};
  assign cnt_next_w = {6'b0, entries_next};
  assign read_ok    = is_read && (idx_w < cnt_w);
  assign slot_sum   = {7'b0, oldest} + {{(PW+1){1'b0}}, q_op.log_index};
  assign slot_fix   = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;
  assign read_slot  = slot_fix[PW-1:0];

  assign req_next = is_run ? q_op.run_active : (q_op.now_ms < run_end);

  assign ram_we    = q_pop && append;
  assign ram_re    = q_pop && read_ok;
  assign ram_wdata = {q_op.now_ms, hum_next};

  hfd_ram #(
    .WIDTH (EW),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (read_slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      avg          <= '0;
      last_time    <= '0;
      run_end      <= '0;
      oldest       <= '0;
      tail         <= '0;
      entries      <= '0;
      trigger      <= hfd_pkg::TRIGGER_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        trigger <= cfg_wdata;
      end
      if (q_pop) begin
        avg     <= avg_next;
        entries <= entries_next;
        if (filter_due) begin
          last_time <= q_op.now_ms;
        end
        if (is_run) begin
          run_end <= q_op.run_end;
        end
        if (append) begin
          tail <= tail_inc;
          if (full) begin
            oldest <= oldest_inc;
          end
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (append) begin
        last_value <= hum_next;
      end
      res_hum   <= hum_next;
      res_req   <= req_next;
      res_count <= cnt_next_w[5:0];
      res_read  <= read_ok;
    end
  end

  always_comb begin
    result.humidity_percent = res_hum;
    result.too_wet          = res_hum > trigger;
    result.run_requested    = res_req;
    result.fan_on           = result.too_wet || res_req;
    result.log_count        = res_count;
    result.log_valid        = res_read;
    result.log_time         = res_read ? ram_rdata[EW-1 -: 32] : 32'd0;
    result.log_humidity     = res_read ? ram_rdata[6:0] : 7'd0;
  end

endmodule

### design/humidity_fan_decider_with_change_log.sv
// ----------------------------------------------------------------------------
// humidity_fan_decider_with_change_log
// filtered humidity threshold with timed manual fan run and a change log of
// integer humidity values
// ----------------------------------------------------------------------------
//
//  channel   handshake                   payload            width
//  --------  --------------------------  -----------------  -----
//  item      item_valid / item_ready     item (item_t)        71
//  result    result_valid / result_ready result (result_t)    56
//  config    cfg_we (no wait)            cfg_wdata             7
//
//  one request per cycle sustained while results are taken; when the queue is
//  empty an accepted request passes the queue register, then the result
//  register, before result_valid rises
//  the back end's state loop (filter multiply-add and log ring pointers) and
//  the one write / one read port of the log memory set the rate
//  rst is synchronous; the log memory is not cleared, a fill count marks valid
//  entries
//  a two-entry queue lets the input side run while a result waits to be taken
//
module humidity_fan_decider_with_change_log #(
  parameter int unsigned LOG_DEPTH        = 60,
  parameter int unsigned FILTER_PERIOD_MS = 1000
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata,
  input  logic             item_valid,
  output logic             item_ready,
  input  hfd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output hfd_pkg::result_t result
);

  // classified request handed from front to back
  logic         q_valid;
  logic         q_pop;
  hfd_pkg::op_t q_op;

  // front: decode kind, form sample and run-end terms, queue
  hfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop)
  );

  // back: state update, log ring, log memory and result register
  hfd_back #(
    .LOG_DEPTH        (LOG_DEPTH),
    .FILTER_PERIOD_MS (FILTER_PERIOD_MS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity fan decider testbench
// drives update, timed-run and log-read requests through the valid/ready
// channels and checks every status word against a hand-written status or a
// cycle-free predictor of filter, trigger compare, run timer and change log
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LOG_DEPTH        = 60;
  localparam int unsigned FILTER_PERIOD_MS = 1000;
  localparam logic [1:0]  KIND_SPARE       = 2'd3;   // unused kind, status only
  localparam int unsigned PHASE_REQUESTS   = 500;
  localparam int unsigned LONG_STALL       = 300;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  // one row of the opening directed sequence
  typedef struct {
    hfd_pkg::item_t   stim;
    bit               pinned;   // want holds a hand-written status
    hfd_pkg::result_t want;
  } opening_row_t;

  logic    clk;
  logic    rst;
  logic    cfg_we;
  logic [6:0] cfg_wdata;
  logic    item_valid;
  logic    item_ready;
  hfd_pkg::item_t   item;
  logic    result_valid;
  logic    result_ready;
  hfd_pkg::result_t result;

  // travels beside the request so the monitor knows a hand-written status
  bit      pinned;
  hfd_pkg::result_t pinned_result;

  // predictor state, starts in the reset state
  logic [22:0] avg_q16      = '0;
  logic [31:0] filter_stamp = '0;
  logic [31:0] run_end      = '0;
  logic [31:0] log_stamp [LOG_DEPTH];
  logic [6:0]  log_level [LOG_DEPTH];
  int unsigned log_head     = 0;
  int unsigned log_fill     = 0;
  logic [6:0]  trigger_level = hfd_pkg::TRIGGER_RESET;

  hfd_pkg::result_t status_due [$];
  int unsigned mismatches = 0;

  // stimulus knobs
  int unsigned sender_idle_pct   = 15;
  int unsigned receiver_idle_pct = 57;
  int unsigned stall_requests    = 0;
  logic [31:0] stim_clock        = '0;
  int          stim_target       = 12800;
  int unsigned elapsed_cycles;

  opening_row_t opening_rows [$];

  humidity_fan_decider_with_change_log #(
    .LOG_DEPTH       (LOG_DEPTH),
    .FILTER_PERIOD_MS(FILTER_PERIOD_MS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring position of the pos-th oldest log entry
  function automatic int unsigned ring_slot(input int unsigned pos);
    return (log_head + pos) % LOG_DEPTH;
  endfunction

  // advances the predictor by one request and returns the status it gives
  function automatic hfd_pkg::result_t decide_fan(input hfd_pkg::item_t stim);
    hfd_pkg::result_t status;
    logic [31:0] elapsed;
    logic [31:0] acc;
    logic [6:0]  level;
    int unsigned slot;
    status = '0;
    case (stim.kind)
      hfd_pkg::KIND_UPDATE: begin
        // modulo 2^32 interval, strictly longer than the period
        elapsed = stim.now_ms - filter_stamp;
        if (elapsed > FILTER_PERIOD_MS) begin
          // avg = (256*sample + 9*avg + 5) / 10, rounds half up
          acc = 32'(stim.sensor_humidity) * 32'd256 + 32'(avg_q16) * 32'd9 + 32'd5;
          avg_q16 = 23'(acc / 32'd10);
          filter_stamp = stim.now_ms;
        end
        level = avg_q16[22:16];
        // empty log always takes the first entry, else only on a change
        if (log_fill == 0 || log_level[ring_slot(log_fill - 1)] != level) begin
          if (log_fill == LOG_DEPTH) begin
            slot = log_head;
            log_head = (log_head + 1) % LOG_DEPTH;
          end else begin
            slot = ring_slot(log_fill);
            log_fill++;
          end
          log_stamp[slot] = stim.now_ms;
          log_level[slot] = level;
        end
      end
      hfd_pkg::KIND_RUN: begin
        // end time wraps; compare below is plain unsigned
        run_end = stim.now_ms + 32'(stim.run_seconds) * 32'd1000;
      end
      hfd_pkg::KIND_READ: begin
        if (stim.log_index < log_fill) begin
          slot = ring_slot(stim.log_index);
          status.log_valid    = 1'b1;
          status.log_time     = log_stamp[slot];
          status.log_humidity = log_level[slot];
        end
      end
      default: begin
      end
    endcase
    status.humidity_percent = avg_q16[22:16];
    status.too_wet          = avg_q16[22:16] > trigger_level;
    status.run_requested    = stim.now_ms < run_end;
    status.fan_on           = status.too_wet | status.run_requested;
    status.log_count        = 6'(log_fill);
    return status;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result check first, then prediction of the request taken at this edge
  always @(posedge clk) begin
    hfd_pkg::result_t want;
    hfd_pkg::result_t predicted;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (status_due.size() == 0) begin
          $error("status word with no request pending");
          mismatches++;
        end else begin
          want = status_due.pop_front();
          check_field("humidity_percent", want.humidity_percent, result.humidity_percent);
          check_field("fan_on", want.fan_on, result.fan_on);
          check_field("too_wet", want.too_wet, result.too_wet);
          check_field("run_requested", want.run_requested, result.run_requested);
          check_field("log_count", want.log_count, result.log_count);
          check_field("log_valid", want.log_valid, result.log_valid);
          check_field("log_time", want.log_time, result.log_time);
          check_field("log_humidity", want.log_humidity, result.log_humidity);
        end
      end
      if (item_valid && item_ready) begin
        predicted = decide_fan(item);
        status_due.insert(status_due.size(), pinned ? pinned_result : predicted);
      end
    end
  end

  // receiver: random back-pressure plus a long hold-off on request
  always @(posedge clk) begin
    int unsigned stall_seen;
    int unsigned stall_left;
    if (stall_requests != stall_seen) begin
      stall_seen = stall_requests;
      stall_left = LONG_STALL;
    end
    if (stall_left != 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // offers one request, with random gaps before it, and returns once taken
  task automatic offer_request(input hfd_pkg::item_t stim, input bit pin,
                               input hfd_pkg::result_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item          <= stim;
    pinned        <= pin;
    pinned_result <= want;
    item_valid    <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // stops offering and waits for every status word, then lets the pipe empty
  task automatic drain_status();
    item_valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // trigger write, only ever called with the block idle
  task automatic write_trigger(input logic [6:0] level);
    cfg_wdata <= level;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we        <= 1'b0;
    trigger_level  = level;
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [31:0] now_ms,
                         input logic [14:0] sample, input logic [15:0] secs,
                         input logic [5:0] index, input bit pin,
                         input hfd_pkg::result_t want);
    opening_row_t row;
    row.stim.kind            = kind;
    row.stim.now_ms          = now_ms;
    row.stim.sensor_humidity = sample;
    row.stim.run_seconds     = secs;
    row.stim.log_index       = index;
    row.pinned               = pin;
    row.want                 = want;
    opening_rows.insert(opening_rows.size(), row);
  endtask

  // mostly ordered time stamps and a wandering humidity, with some noise
  function automatic hfd_pkg::item_t random_request();
    hfd_pkg::item_t stim;
    int unsigned roll;
    int          sample;
    // fields a kind does not use still carry random bits
    stim.now_ms          = $urandom;
    stim.sensor_humidity = 15'($urandom);
    stim.run_seconds     = 16'($urandom);
    stim.log_index       = 6'($urandom);
    // occasional jump anywhere: wraps, goes backward, skips far ahead
    if ($urandom_range(49) == 0) stim_clock = $urandom;
    else stim_clock = stim_clock + $urandom_range(2500);
    stim.now_ms = stim_clock;
    roll = $urandom_range(99);
    if (roll < 55) begin
      stim.kind = hfd_pkg::KIND_UPDATE;
      stim_target = stim_target + int'($urandom_range(6000)) - 3000;
      if (stim_target < 0) stim_target = 0;
      if (stim_target > 25600) stim_target = 25600;
      sample = stim_target + int'($urandom_range(1600)) - 800;
      if (sample < 0) sample = 0;
      if (sample > 25600) sample = 25600;
      stim.sensor_humidity = 15'(sample);
      // rare samples over the full field, past 100 percent
      if ($urandom_range(32) == 0) stim.sensor_humidity = 15'($urandom);
    end else if (roll < 70) begin
      stim.kind = hfd_pkg::KIND_RUN;
      if ($urandom_range(4) != 0) stim.run_seconds = 16'($urandom_range(120));
    end else if (roll < 95) begin
      stim.kind = hfd_pkg::KIND_READ;
      if ($urandom_range(5) != 0) stim.log_index = 6'($urandom_range(LOG_DEPTH - 1));
    end else begin
      stim.kind = KIND_SPARE;
    end
    return stim;
  endfunction

  initial begin
    int unsigned step;
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    item_valid    = 1'b0;
    item          = '0;
    pinned        = 1'b0;
    pinned_result = '0;
    result_ready  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // status fields: humidity, fan, wet, run, count, valid, time, level
    // read of an empty log right after reset
    add_row(hfd_pkg::KIND_READ, 32'd0, 15'd0, 16'd0, 6'd0, 1,
            hfd_pkg::result_t'{7'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 32'd0, 7'd0});
    // unused kind with every field at its top, touches no state
    add_row(KIND_SPARE, 32'hFFFF_FFFF, 15'h7FFF, 16'hFFFF, 6'h3F, 1,
            hfd_pkg::result_t'{7'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 32'd0, 7'd0});
    // too early to filter, but the empty log takes the first entry
    add_row(hfd_pkg::KIND_UPDATE, 32'd500, 15'd25600, 16'd0, 6'd0, 1,
            hfd_pkg::result_t'{7'd0, 1'b0, 1'b0, 1'b0, 6'd1, 1'b0, 32'd0, 7'd0});
    // exactly one period is not enough, no change to log
    add_row(hfd_pkg::KIND_UPDATE, 32'd1000, 15'd25600, 16'd0, 6'd0, 1,
            hfd_pkg::result_t'{7'd0, 1'b0, 1'b0, 1'b0, 6'd1, 1'b0, 32'd0, 7'd0});
    // one past the period: full-scale sample lifts the average to 10 percent
    add_row(hfd_pkg::KIND_UPDATE, 32'd1001, 15'd25600, 16'd0, 6'd0, 1,
            hfd_pkg::result_t'{7'd10, 1'b0, 1'b0, 1'b0, 6'd2, 1'b0, 32'd0, 7'd0});
    // both entries, then the first index past the end and the last index
    add_row(hfd_pkg::KIND_READ, 32'd1001, 15'd0, 16'd0, 6'd0, 1,
            hfd_pkg::result_t'{7'd10, 1'b0, 1'b0, 1'b0, 6'd2, 1'b1, 32'd500, 7'd0});
    add_row(hfd_pkg::KIND_READ, 32'd1001, 15'd0, 16'd0, 6'd1, 1,
            hfd_pkg::result_t'{7'd10, 1'b0, 1'b0, 1'b0, 6'd2, 1'b1, 32'd1001, 7'd10});
    add_row(hfd_pkg::KIND_READ, 32'd1001, 15'd0, 16'd0, 6'd2, 1,
            hfd_pkg::result_t'{7'd10, 1'b0, 1'b0, 1'b0, 6'd2, 1'b0, 32'd0, 7'd0});
    add_row(hfd_pkg::KIND_READ, 32'd1001, 15'd0, 16'd0, 6'd63, 1,
            hfd_pkg::result_t'{7'd10, 1'b0, 1'b0, 1'b0, 6'd2, 1'b0, 32'd0, 7'd0});
    // zero-second run is never active
    add_row(hfd_pkg::KIND_RUN, 32'd2000, 15'd0, 16'd0, 6'd0, 1,
            hfd_pkg::result_t'{7'd10, 1'b0, 1'b0, 1'b0, 6'd2, 1'b0, 32'd0, 7'd0});
    // longest run
    add_row(hfd_pkg::KIND_RUN, 32'd2000, 15'd0, 16'hFFFF, 6'd0, 1,
            hfd_pkg::result_t'{7'd10, 1'b1, 1'b0, 1'b1, 6'd2, 1'b0, 32'd0, 7'd0});
    // run ending just below the wrap is active
    add_row(hfd_pkg::KIND_RUN, 32'hFFFF_0000, 15'd0, 16'd1, 6'd0, 1,
            hfd_pkg::result_t'{7'd10, 1'b1, 1'b0, 1'b1, 6'd2, 1'b0, 32'd0, 7'd0});
    // run whose end wraps past 2^32 counts as expired
    add_row(hfd_pkg::KIND_RUN, 32'hFFFF_FF00, 15'd0, 16'd1, 6'd0, 1,
            hfd_pkg::result_t'{7'd10, 1'b0, 1'b0, 1'b0, 6'd2, 1'b0, 32'd0, 7'd0});
    // from here on the predictor supplies the status
    add_row(hfd_pkg::KIND_RUN, 32'h5555_0000, 15'h2AAA, 16'h5555, 6'h2A, 0, '0);
    add_row(hfd_pkg::KIND_UPDATE, 32'h0000_3000, 15'h7FFF, 16'hAAAA, 6'h15, 0, '0);
    // climb toward the trigger, staying below it
    for (step = 0; step < 7; step++)
      add_row(hfd_pkg::KIND_UPDATE, 32'h0000_4000 + step * 32'h1000, 15'd25600,
              16'd0, 6'd0, 0, '0);
    // time going backward looks like a long interval
    add_row(hfd_pkg::KIND_UPDATE, 32'h0000_0100, 15'd0, 16'd0, 6'd0, 0, '0);
    add_row(hfd_pkg::KIND_UPDATE, 32'h0000_0200, 15'h5555, 16'd0, 6'd0, 0, '0);
    add_row(hfd_pkg::KIND_READ, 32'h0000_0300, 15'd0, 16'd0, 6'd3, 0, '0);
    add_row(KIND_SPARE, 32'hAAAA_AAAA, 15'h2AAA, 16'h5555, 6'h15, 0, '0);

    foreach (opening_rows[i])
      offer_request(opening_rows[i].stim, opening_rows[i].pinned, opening_rows[i].want);
    drain_status();
    stim_clock = 32'h0001_0000;

    // four random phases, each with a trigger; phases 2 and 3 share idle rates
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_trigger(7'd0);
        1: write_trigger(7'd100);
        default: write_trigger(7'($urandom_range(100)));
      endcase
      sender_idle_pct   = (phase == 0) ? 15 : (phase == 1) ? 57 : 0;
      receiver_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 15 : 0;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // receiver holds off while requests keep coming: queue fills, input stalls
        if (phase == 2 && n == PHASE_REQUESTS / 2) stall_requests++;
        // sender waits for every outstanding status word
        if (phase == 3 && n == PHASE_REQUESTS / 2) drain_status();
        offer_request(random_request(), 1'b0, '0);
      end
      drain_status();
    end

    if (mismatches == 0) begin
      $display("humidity_fan_decider_with_change_log: match");
    end else begin
      $display("humidity_fan_decider_with_change_log: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    elapsed_cycles = 0;
    while (elapsed_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      elapsed_cycles++;
    end
    $display("humidity_fan_decider_with_change_log: mismatch");
    $finish;
  end

endmodule
